FILE: rtl/urc_pkg.sv
// ----------------------------------------------------------------------------
// urc_pkg: shared types and constants of the ultrasonic ranging controller
// Field widths, FIFO sizing, command and status codes, and register indexes.
// ----------------------------------------------------------------------------
package urc_pkg;

  // FIFO sizing and distance resolution.
  localparam int unsigned FIFO_DEPTH    = 8;
  localparam int unsigned DISTANCE_BITS = 10;
  localparam int unsigned IDX_W         = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W         = $clog2(FIFO_DEPTH + 1);

  localparam logic [CNT_W-1:0]         FIFO_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [IDX_W-1:0]         IDX_LAST  = IDX_W'(FIFO_DEPTH - 1);
  localparam logic [DISTANCE_BITS-1:0] DIST_MAX  = {DISTANCE_BITS{1'b1}};

  // Configuration register widths.
  localparam int unsigned PERIOD_W   = 29;
  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned TPC_W      = 16;
  localparam int unsigned HOLD_W     = 25;
  localparam int unsigned CFG_DATA_W = PERIOD_W;
  localparam int unsigned CFG_IDX_W  = 3;

  // Configuration register reset values.
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(25000000);
  localparam logic [PULSE_W-1:0]  PULSE_RST  = PULSE_W'(4000);
  localparam logic [TPC_W-1:0]    TPC_RST    = TPC_W'(23200);
  localparam logic [HOLD_W-1:0]   HOLD_RST   = HOLD_W'(24000000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONT_MODE = 3'd0,
    REG_PERIOD    = 3'd1,
    REG_PULSE     = 3'd2,
    REG_TPC       = 3'd3,
    REG_HOLDOFF   = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_EMPTY_SHOT = 2'd1,
    STAT_EMPTY_CONT = 2'd2
  } read_status_e;

  // Host requests toward the trigger generator.
  typedef struct packed {
    logic start;
    logic stop;
  } trig_ctrl_t;

  // Requests toward the distance FIFO.
  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
  } fifo_ctrl_t;

  // FIFO status back to the top level.
  typedef struct packed {
    logic empty;
    logic pop_valid;
  } fifo_stat_t;

  // Finished echo measurement.
  typedef struct packed {
    logic                     done;
    logic [DISTANCE_BITS-1:0] distance;
  } echo_res_t;

  // Circular index advance that also works for depths other than powers of two.
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    next_idx = (idx == IDX_LAST) ? '0 : idx + 1'b1;
  endfunction

endpackage

FILE: rtl/urc_trigger.sv
// ----------------------------------------------------------------------------
// urc_trigger: trigger pulse generator
// Periodic pulses in continuous mode, single shot plus hold-off otherwise.
// ----------------------------------------------------------------------------
module urc_trigger (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  urc_pkg::trig_ctrl_t           ctrl_i,
  input  logic                          cont_mode_i,
  input  logic [urc_pkg::PERIOD_W-1:0]  period_i,
  input  logic [urc_pkg::PULSE_W-1:0]   pulse_i,
  input  logic [urc_pkg::HOLD_W-1:0]    holdoff_i,
  output logic                          trig_o
);

  logic                         active_q, active_d;
  logic [urc_pkg::PERIOD_W-1:0] phase_q, phase_d;
  logic                         active_mid;
  logic [urc_pkg::PERIOD_W-1:0] phase_mid;
  logic [urc_pkg::PERIOD_W:0]   phase_inc;
  logic [urc_pkg::HOLD_W:0]     shot_len;

  assign shot_len = {1'b0, holdoff_i} + (urc_pkg::HOLD_W + 1)'(pulse_i);

  always_comb begin
    // Host requests act first; a start while active is ignored.
    active_mid = active_q;
    phase_mid  = phase_q;
    if (ctrl_i.stop) begin
      active_mid = 1'b0;
      phase_mid  = '0;
    end else if (ctrl_i.start && !active_q) begin
      active_mid = 1'b1;
      phase_mid  = '0;
    end

    phase_inc = {1'b0, phase_mid} + 1'b1;
    active_d  = active_mid;
    phase_d   = phase_mid;
    trig_o    = 1'b0;
    if (active_mid) begin
      trig_o = (phase_mid < urc_pkg::PERIOD_W'(pulse_i));
      if (cont_mode_i) begin
        phase_d = (phase_inc >= {1'b0, period_i}) ? '0 : phase_inc[urc_pkg::PERIOD_W-1:0];
      end else if (phase_inc >= (urc_pkg::PERIOD_W + 1)'(shot_len)) begin
        active_d = 1'b0;
        phase_d  = '0;
      end else begin
        phase_d = phase_inc[urc_pkg::PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      phase_q  <= '0;
    end else if (step_i) begin
      active_q <= active_d;
      phase_q  <= phase_d;
    end
  end

endmodule

FILE: rtl/urc_echo.sv
// ----------------------------------------------------------------------------
// urc_echo: echo pulse timer
// Converts the echo-high time into whole centimeters, saturating.
// ----------------------------------------------------------------------------
module urc_echo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      echo_i,
  input  logic [urc_pkg::TPC_W-1:0] ticks_per_cm_i,
  output urc_pkg::echo_res_t        res_o
);

  logic                              prev_q;
  logic [urc_pkg::TPC_W-1:0]         tick_q, tick_d, tick_cur;
  logic [urc_pkg::DISTANCE_BITS-1:0] cm_q, cm_d, cm_cur;
  logic [urc_pkg::TPC_W:0]           tick_inc;

  always_comb begin
    // A rising edge restarts both counters, and its own tick counts.
    tick_cur = (echo_i && !prev_q) ? '0 : tick_q;
    cm_cur   = (echo_i && !prev_q) ? '0 : cm_q;
    tick_inc = {1'b0, tick_cur} + 1'b1;
    tick_d   = tick_q;
    cm_d     = cm_q;
    if (echo_i) begin
      if (tick_inc >= {1'b0, ticks_per_cm_i}) begin
        tick_d = '0;
        cm_d   = (cm_cur < urc_pkg::DIST_MAX) ? cm_cur + 1'b1 : cm_cur;
      end else begin
        tick_d = tick_inc[urc_pkg::TPC_W-1:0];
        cm_d   = cm_cur;
      end
    end
    res_o.done     = !echo_i && prev_q;
    res_o.distance = cm_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      tick_q <= '0;
      cm_q   <= '0;
    end else if (step_i) begin
      prev_q <= echo_i;
      tick_q <= tick_d;
      cm_q   <= cm_d;
    end
  end

endmodule

FILE: rtl/urc_fifo.sv
// ----------------------------------------------------------------------------
// urc_fifo: distance FIFO
// Circular store that overwrites its oldest entry when a push finds it full.
// ----------------------------------------------------------------------------
module urc_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  urc_pkg::fifo_ctrl_t               ctrl_i,
  input  logic [urc_pkg::DISTANCE_BITS-1:0] push_data_i,
  output urc_pkg::fifo_stat_t               stat_o,
  output logic [urc_pkg::DISTANCE_BITS-1:0] pop_data_o,
  output logic [urc_pkg::CNT_W-1:0]         count_o
);

  logic [urc_pkg::DISTANCE_BITS-1:0] store_q [urc_pkg::FIFO_DEPTH];
  logic [urc_pkg::IDX_W-1:0]         wr_idx_q, wr_idx_d, wr_mid;
  logic [urc_pkg::IDX_W-1:0]         rd_idx_q, rd_idx_d, rd_mid;
  logic [urc_pkg::CNT_W-1:0]         cnt_q, cnt_d, cnt_mid;
  logic                              pop_ok;

  assign stat_o.empty     = (cnt_q == '0);
  assign pop_ok           = ctrl_i.pop && (cnt_q != '0);
  assign stat_o.pop_valid = pop_ok;
  assign pop_data_o       = pop_ok ? store_q[rd_idx_q] : '0;

  always_comb begin
    // Clear or pop first, then the push of this tick.
    wr_mid  = wr_idx_q;
    rd_mid  = rd_idx_q;
    cnt_mid = cnt_q;
    if (ctrl_i.clear) begin
      wr_mid  = '0;
      rd_mid  = '0;
      cnt_mid = '0;
    end else if (pop_ok) begin
      rd_mid  = urc_pkg::next_idx(rd_idx_q);
      cnt_mid = cnt_q - 1'b1;
    end
    wr_idx_d = wr_mid;
    rd_idx_d = rd_mid;
    cnt_d    = cnt_mid;
    if (ctrl_i.push) begin
      wr_idx_d = urc_pkg::next_idx(wr_mid);
      if (cnt_mid == urc_pkg::FIFO_FULL) begin
        rd_idx_d = urc_pkg::next_idx(rd_mid);
      end else begin
        cnt_d = cnt_mid + 1'b1;
      end
    end
    count_o = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      cnt_q    <= '0;
    end else if (step_i) begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entries are undefined until written, so the store has no reset.
  always_ff @(posedge clk_i) begin
    if (step_i && ctrl_i.push) begin
      store_q[wr_mid] <= push_data_i;
    end
  end

endmodule

FILE: rtl/ultrasonic_ranging_controller_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranging_controller_top: ultrasonic echo ranging controller
// Output: the result word of a tick is registered at the edge that takes the tick.
// Throughput: one tick word per cycle unless the consumer stalls, set by the single state update per tick.
// Reset: asynchronous; clears all control state and loads the register defaults.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_controller_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Tick input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                echo_level_i,
  input  logic [1:0]                          command_i,
  input  logic                                write_value_i,
  // Result output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                trigger_level_o,
  output logic                                read_valid_o,
  output logic [urc_pkg::DISTANCE_BITS-1:0]   read_distance_o,
  output logic [1:0]                          read_status_o,
  output logic                                measurement_done_o,
  output logic [urc_pkg::CNT_W-1:0]           fifo_count_o,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [urc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [urc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // Each input word is one tick of the timing base. At the accepting edge the
  // whole tick is evaluated: host command, trigger phase, echo timing and the
  // FIFO update all commit together, and the result word is captured in the
  // output register. The input side is stalled only while that register holds
  // a word the consumer has not taken, so a new tick enters every cycle while
  // the output flows.

  // --------------------------------------------------------------------------
  // Configuration registers. The write port never back-pressures.
  // --------------------------------------------------------------------------
  logic                          cont_mode_q;
  logic [urc_pkg::PERIOD_W-1:0]  period_q;
  logic [urc_pkg::PULSE_W-1:0]   pulse_q;
  logic [urc_pkg::TPC_W-1:0]     tpc_q;
  logic [urc_pkg::HOLD_W-1:0]    holdoff_q;
  urc_pkg::cfg_reg_e             cfg_reg;

  assign cfg_ready_o = 1'b1;
  assign cfg_reg     = urc_pkg::cfg_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_mode_q <= 1'b0;
      period_q    <= urc_pkg::PERIOD_RST;
      pulse_q     <= urc_pkg::PULSE_RST;
      tpc_q       <= urc_pkg::TPC_RST;
      holdoff_q   <= urc_pkg::HOLD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg)
        urc_pkg::REG_CONT_MODE: cont_mode_q <= cfg_data_i[0];
        urc_pkg::REG_PERIOD:    period_q    <= cfg_data_i;
        urc_pkg::REG_PULSE:     pulse_q     <= cfg_data_i[urc_pkg::PULSE_W-1:0];
        urc_pkg::REG_TPC:       tpc_q       <= cfg_data_i[urc_pkg::TPC_W-1:0];
        urc_pkg::REG_HOLDOFF:   holdoff_q   <= cfg_data_i[urc_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. A tick is taken whenever the output register is free or is
  // being emptied in this same cycle.
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic step;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign step       = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Host command decode. Command three is unused and does nothing.
  // --------------------------------------------------------------------------
  urc_pkg::cmd_e          cmd;
  logic                   is_write, is_read;
  urc_pkg::trig_ctrl_t    trig_ctrl;
  urc_pkg::fifo_ctrl_t    fifo_ctrl;
  urc_pkg::fifo_stat_t    fifo_stat;
  urc_pkg::echo_res_t     echo_res;
  urc_pkg::read_status_e  status;
  logic                   trig_level;
  logic [urc_pkg::DISTANCE_BITS-1:0] pop_data;
  logic [urc_pkg::CNT_W-1:0]         fifo_count;

  assign cmd      = urc_pkg::cmd_e'(command_i);
  assign is_write = (cmd == urc_pkg::CMD_WRITE);
  assign is_read  = (cmd == urc_pkg::CMD_READ);

  always_comb begin
    // In continuous mode a write of zero stops and a write of one starts.
    // In one-shot mode any write starts a shot, and a nonzero value also
    // empties the FIFO. A read that finds the FIFO empty in one-shot mode
    // fires a shot as well. The trigger unit ignores a start while busy.
    trig_ctrl.stop  = is_write && cont_mode_q && !write_value_i;
    trig_ctrl.start = (is_write && (!cont_mode_q || write_value_i))
                   || (is_read && fifo_stat.empty && !cont_mode_q);
    fifo_ctrl.clear = is_write && !cont_mode_q && write_value_i;
    fifo_ctrl.pop   = is_read;
    fifo_ctrl.push  = echo_res.done;

    status = urc_pkg::STAT_OK;
    if (is_read && fifo_stat.empty) begin
      status = cont_mode_q ? urc_pkg::STAT_EMPTY_CONT : urc_pkg::STAT_EMPTY_SHOT;
    end
  end

  urc_trigger u_trigger (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .ctrl_i      (trig_ctrl),
    .cont_mode_i (cont_mode_q),
    .period_i    (period_q),
    .pulse_i     (pulse_q),
    .holdoff_i   (holdoff_q),
    .trig_o      (trig_level)
  );

  urc_echo u_echo (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .echo_i         (echo_level_i),
    .ticks_per_cm_i (tpc_q),
    .res_o          (echo_res)
  );

  urc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .ctrl_i      (fifo_ctrl),
    .push_data_i (echo_res.distance),
    .stat_o      (fifo_stat),
    .pop_data_o  (pop_data),
    .count_o     (fifo_count)
  );

  // --------------------------------------------------------------------------
  // Result register. The payload loads only when a tick is taken, so it holds
  // steady while the consumer stalls.
  // --------------------------------------------------------------------------
  logic                              trig_q;
  logic                              rd_valid_q;
  logic [urc_pkg::DISTANCE_BITS-1:0] rd_dist_q;
  urc_pkg::read_status_e             rd_status_q;
  logic                              done_q;
  logic [urc_pkg::CNT_W-1:0]         count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      trig_q      <= trig_level;
      rd_valid_q  <= fifo_stat.pop_valid;
      rd_dist_q   <= pop_data;
      rd_status_q <= status;
      done_q      <= echo_res.done;
      count_q     <= fifo_count;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign trigger_level_o    = trig_q;
  assign read_valid_o       = rd_valid_q;
  assign read_distance_o    = rd_dist_q;
  assign read_status_o      = rd_status_q;
  assign measurement_done_o = done_q;
  assign fifo_count_o       = count_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output register");

  a_accept_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted tick produced no result word");

  a_pop_excludes_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(read_valid_o && (read_status_o != urc_pkg::STAT_OK)))
    else $error("read popped a distance and reported empty at once");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fifo_count_o <= urc_pkg::FIFO_FULL))
    else $error("FIFO count above depth");

  a_empty_read_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && is_read && fifo_stat.empty) |=> !read_valid_o)
    else $error("read on an empty FIFO returned a distance");

endmodule

FILE: bench/ultrasonic_ranging_controller_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_ranging_controller_top_test: tick-level testbench of the ranger
// Every input word is one tick of the timing base. A predictor in this file
// tracks the trigger generator, echo timer and distance FIFO, and each output
// word is checked field by field against the prediction for the same tick.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_controller_top_test;
  import urc_pkg::*;

  // Command code 3 is legal on the port but means nothing to the block.
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned MAX_GAP     = 15;
  localparam int unsigned CLK_HALF    = 5;

  // One output word, laid out in port order.
  typedef struct packed {
    logic                     trig;
    logic                     rd_valid;
    logic [DISTANCE_BITS-1:0] rd_dist;
    logic [1:0]               rd_status;
    logic                     done;
    logic [CNT_W-1:0]         count;
  } tick_result_t;

  // Every input of the block starts at a known value.
  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_stall_o;
  logic                     echo_level_i  = 1'b0;
  logic [1:0]               command_i     = CMD_NONE;
  logic                     write_value_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i   = 1'b0;
  logic                     trigger_level_o;
  logic                     read_valid_o;
  logic [DISTANCE_BITS-1:0] read_distance_o;
  logic [1:0]               read_status_o;
  logic                     measurement_done_o;
  logic [CNT_W-1:0]         fifo_count_o;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i   = REG_CONT_MODE;
  logic [CFG_DATA_W-1:0]    cfg_data_i    = '0;

  // Bench control. The idle switches let each test choose between random
  // gaps on a side and a side that never idles.
  bit           src_idle_en      = 1'b0;
  bit           sink_idle_en     = 1'b0;
  int unsigned  sink_hold_cycles = 0;
  int unsigned  fail_count       = 0;
  int unsigned  checked_count    = 0;
  tick_result_t tick_outputs_q [$];

  // Predictor copy of the registers, starting from their reset values.
  logic            cont_mode  = 1'b0;
  longint unsigned period_cfg = PERIOD_RST;
  longint unsigned pulse_cfg  = PULSE_RST;
  longint unsigned tpc_cfg    = TPC_RST;
  longint unsigned hold_cfg   = HOLD_RST;

  // Predictor state. Store entries are only read after they were pushed,
  // so the store itself needs no reset.
  logic [DISTANCE_BITS-1:0] dist_mem [FIFO_DEPTH];
  int unsigned              wr_ptr    = 0;
  int unsigned              rd_ptr    = 0;
  int unsigned              held      = 0;
  logic                     echo_prev = 1'b0;
  int unsigned              sub_ticks = 0;
  int unsigned              cm_count  = 0;
  logic                     trig_on   = 1'b0;
  longint unsigned          phase     = 0;

  ultrasonic_ranging_controller_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .echo_level_i       (echo_level_i),
    .command_i          (command_i),
    .write_value_i      (write_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .trigger_level_o    (trigger_level_o),
    .read_valid_o       (read_valid_o),
    .read_distance_o    (read_distance_o),
    .read_status_o      (read_status_o),
    .measurement_done_o (measurement_done_o),
    .fifo_count_o       (fifo_count_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // A shot, or the first pulse of continuous triggering, starts at phase zero.
  function automatic void begin_shot();
    trig_on = 1'b1;
    phase   = 0;
  endfunction

  // Advances the predicted block by one tick and returns the output word of
  // that tick. Within a tick the host command acts first, then the trigger
  // generator, then the echo timer and the FIFO push.
  function automatic tick_result_t next_tick_outputs(logic echo, logic [1:0] cmd,
                                                     logic wval);
    tick_result_t    r;
    longint unsigned nxt;
    r = '0;

    if (cmd == CMD_WRITE) begin
      if (cont_mode) begin
        // Zero stops and rewinds; one starts unless already running.
        if (!wval) begin
          trig_on = 1'b0;
          phase   = 0;
        end else if (!trig_on) begin
          begin_shot();
        end
      end else begin
        // One-shot write fires a shot if idle, and a nonzero value also
        // empties the FIFO.
        if (!trig_on) begin_shot();
        if (wval) begin
          wr_ptr = 0;
          rd_ptr = 0;
          held   = 0;
        end
      end
    end else if (cmd == CMD_READ) begin
      if (held > 0) begin
        r.rd_valid = 1'b1;
        r.rd_dist  = dist_mem[rd_ptr];
        rd_ptr     = (rd_ptr + 1) % FIFO_DEPTH;
        held--;
      end else if (cont_mode) begin
        r.rd_status = STAT_EMPTY_CONT;
      end else begin
        // An empty read in one-shot mode doubles as a shot request.
        r.rd_status = STAT_EMPTY_SHOT;
        if (!trig_on) begin_shot();
      end
    end

    if (trig_on) begin
      nxt    = phase + 1;
      r.trig = (phase < pulse_cfg);
      if (cont_mode) begin
        // A zero period behaves as a period of one tick.
        phase = (nxt >= period_cfg) ? 0 : nxt;
      end else if (nxt >= pulse_cfg + hold_cfg) begin
        trig_on = 1'b0;
        phase   = 0;
      end else begin
        phase = nxt;
      end
    end

    if (echo) begin
      // The rising edge restarts both counters and the edge tick counts.
      if (!echo_prev) begin
        sub_ticks = 0;
        cm_count  = 0;
      end
      if (sub_ticks + 1 >= tpc_cfg) begin
        sub_ticks = 0;
        if (cm_count < DIST_MAX) cm_count++;
      end else begin
        sub_ticks++;
      end
    end else if (echo_prev) begin
      // Falling edge: push, and drop the oldest entry when full.
      dist_mem[wr_ptr] = DISTANCE_BITS'(cm_count);
      wr_ptr           = (wr_ptr + 1) % FIFO_DEPTH;
      if (held >= FIFO_DEPTH) rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
      else held++;
      r.done = 1'b1;
    end
    echo_prev = echo;

    r.count = CNT_W'(held);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one tick word, optionally after a random gap, and predicts its
  // outputs at the edge where the block takes it. The task returns right
  // after that edge with valid still high, so a following call can present
  // the next word without a bubble.
  task automatic send_tick(input logic echo, input logic [1:0] cmd, input logic wval);
    int unsigned gap;
    gap = src_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    echo_level_i  <= echo;
    command_i     <= cmd;
    write_value_i <= wval;
    do @(posedge clk_i); while (in_stall_o);
    tick_outputs_q.push_back(next_tick_outputs(echo, cmd, wval));
  endtask

  // Stops offering words and waits until every predicted word has come out.
  // Each tick yields exactly one output word, so an empty queue means idle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tick_outputs_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes all five registers back to back while the block is idle. Valid
  // stays high across the writes and drops only after the last one.
  task automatic load_settings(input logic mode, input int unsigned period,
                               input int unsigned pulse, input int unsigned per_cm,
                               input int unsigned hold);
    cfg_reg_e              regs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    regs = '{REG_CONT_MODE, REG_PERIOD, REG_PULSE, REG_TPC, REG_HOLDOFF};
    vals = '{CFG_DATA_W'(mode), CFG_DATA_W'(period), CFG_DATA_W'(pulse),
             CFG_DATA_W'(per_cm), CFG_DATA_W'(hold)};
    drain_results();
    foreach (regs[r]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[r];
      cfg_data_i  <= vals[r];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (regs[r])
        REG_CONT_MODE: cont_mode  = vals[r][0];
        REG_PERIOD:    period_cfg = vals[r][PERIOD_W-1:0];
        REG_PULSE:     pulse_cfg  = vals[r][PULSE_W-1:0];
        REG_TPC:       tpc_cfg    = vals[r][TPC_W-1:0];
        REG_HOLDOFF:   hold_cfg   = vals[r][HOLD_W-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic shaped like a real sensor: the echo pin alternates between
  // runs of high and low ticks, and host accesses are sprinkled on top. With
  // long_echo set, the first high run lasts long enough to drive the
  // distance into saturation when a centimeter takes at most one tick.
  task automatic run_random_ticks(input int unsigned n_ticks, input int unsigned read_pct,
                                  input int unsigned write_pct, input bit long_echo);
    int unsigned run_left;
    int unsigned roll;
    logic        echo;
    logic [1:0]  cmd;
    echo     = 1'b0;
    run_left = $urandom_range(1, 6);
    repeat (n_ticks) begin
      if (run_left == 0) begin
        echo = ~echo;
        if (echo && long_echo) begin
          run_left  = $urandom_range(1030, 1060);
          long_echo = 1'b0;
        end else begin
          run_left = echo ? $urandom_range(1, 14) : $urandom_range(1, 8);
        end
      end
      run_left--;
      roll = $urandom_range(0, 99);
      if (roll < read_pct) cmd = CMD_READ;
      else if (roll < read_pct + write_pct) cmd = CMD_WRITE;
      else if (roll < read_pct + write_pct + 2) cmd = CMD_UNUSED;
      else cmd = CMD_NONE;
      send_tick(echo, cmd, 1'($urandom_range(0, 1)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // With its idle switch on, the receiver draws a fresh wait after every word it
  // takes. A long hold requested by a test takes priority and is counted down
  // here, independent of the sender.
  initial begin : result_sink
    int unsigned gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i && sink_idle_en) gap_left = $urandom_range(0, MAX_GAP);
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic string fmt_tick(tick_result_t r);
    return $sformatf("trig=%0b rvalid=%0b dist=%0d status=%0d done=%0b count=%0d",
                     r.trig, r.rd_valid, r.rd_dist, r.rd_status, r.done, r.count);
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  // Every word taken from the block is compared with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    tick_result_t got;
    tick_result_t want;
    string        diff;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {trigger_level_o, read_valid_o, read_distance_o, read_status_o,
             measurement_done_o, fifo_count_o};
      if (tick_outputs_q.size() == 0) begin
        note_failure({"output word with no tick pending: ", fmt_tick(got)});
      end else begin
        want = tick_outputs_q.pop_front();
        diff = "";
        if (got.trig      !== want.trig)      diff = {diff, " trigger_level"};
        if (got.rd_valid  !== want.rd_valid)  diff = {diff, " read_valid"};
        if (got.rd_dist   !== want.rd_dist)   diff = {diff, " read_distance"};
        if (got.rd_status !== want.rd_status) diff = {diff, " read_status"};
        if (got.done      !== want.done)      diff = {diff, " measurement_done"};
        if (got.count     !== want.count)     diff = {diff, " fifo_count"};
        if (diff != "") begin
          note_failure($sformatf("tick %0d differs in%s; expected %s, got %s",
                                 checked_count, diff, fmt_tick(want), fmt_tick(got)));
        end
      end
      checked_count++;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Registers still hold their reset values: a one-shot trigger with a wide
  // pulse and a centimeter so long that short echoes measure zero.
  task automatic test_default_settings();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_tick(1'b0, CMD_READ, 1'b0);   // empty FIFO: status and a fresh shot
    send_tick(1'b0, CMD_NONE, 1'b0);
    send_tick(1'b1, CMD_READ, 1'b0);   // shot under way, so nothing restarts
    send_tick(1'b0, CMD_NONE, 1'b0);   // falling edge stores a distance
    send_tick(1'b0, CMD_READ, 1'b0);   // and the read pops it
  endtask

  // Short directed walk through every command in both modes.
  task automatic test_directed_commands();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    // One-shot with a two-tick pulse and one tick of hold-off; the shot
    // left over from the defaults ends as soon as its phase passes three.
    load_settings(1'b0, 3, 2, 2, 1);
    send_tick(1'b1, CMD_NONE,   1'b0);  // single-tick echo pulse
    send_tick(1'b0, CMD_NONE,   1'b0);
    send_tick(1'b1, CMD_WRITE,  1'b0);  // shot without clearing
    send_tick(1'b1, CMD_NONE,   1'b0);
    send_tick(1'b1, CMD_UNUSED, 1'b1);  // unused code with write data set
    send_tick(1'b1, CMD_NONE,   1'b0);
    send_tick(1'b0, CMD_READ,   1'b0);  // pop while the echo falls
    send_tick(1'b0, CMD_READ,   1'b0);
    send_tick(1'b1, CMD_WRITE,  1'b1);  // clear the FIFO
    send_tick(1'b0, CMD_READ,   1'b1);  // empty read, then a push behind it
    // Continuous with a three-tick period and one-tick pulse.
    load_settings(1'b1, 3, 1, 1, 0);
    send_tick(1'b0, CMD_WRITE,  1'b1);  // start
    send_tick(1'b0, CMD_NONE,   1'b0);
    send_tick(1'b0, CMD_WRITE,  1'b1);  // start while running is ignored
    send_tick(1'b0, CMD_READ,   1'b0);
    send_tick(1'b0, CMD_READ,   1'b0);  // empty in continuous mode
    send_tick(1'b0, CMD_WRITE,  1'b0);  // stop
    send_tick(1'b0, CMD_NONE,   1'b0);
  endtask

  task automatic test_oneshot_traffic();
    load_settings(1'b0, 9, 3, 3, 6);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    run_random_ticks(80, 15, 5, 1'b0);
  endtask

  task automatic test_continuous_traffic();
    load_settings(1'b1, 11, 4, 2, 5);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b1;
    run_random_ticks(80, 12, 6, 1'b0);
  endtask

  // Zero period, zero pulse width and zero ticks per centimeter.
  task automatic test_zero_settings();
    load_settings(1'b1, 0, 0, 0, 0);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b0;
    run_random_ticks(60, 10, 8, 1'b0);
  endtask

  // Rare reads let the FIFO wrap and overwrite its oldest entries.
  task automatic test_fifo_overflow();
    load_settings(1'b1, 1, 1, 65535, 0);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_random_ticks(120, 2, 2, 1'b0);
  endtask

  // Largest pulse and hold-off and a long period; one tick per centimeter with one
  // echo long enough to saturate the distance.
  task automatic test_extreme_settings();
    load_settings(1'b0, 400000000, 65535, 1, 33554431);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b1;
    run_random_ticks(1080, 5, 2, 1'b1);
  endtask

  // A shot of a single tick: one-tick pulse with no hold-off at all.
  task automatic test_single_tick_shot();
    load_settings(1'b0, 2, 1, 4, 0);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    run_random_ticks(50, 25, 10, 1'b0);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      load_settings(1'($urandom_range(0, 1)), $urandom_range(0, 20), $urandom_range(0, 8),
                    $urandom_range(0, 6), $urandom_range(0, 12));
      src_idle_en  = 1'($urandom_range(0, 1));
      sink_idle_en = 1'($urandom_range(0, 1));
      run_random_ticks(30, $urandom_range(3, 20), $urandom_range(1, 8), 1'b0);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering words, so the block fills up and stalls its input.
  task automatic test_backpressure();
    load_settings(1'b1, 5, 2, 1, 0);
    src_idle_en      = 1'b0;
    sink_idle_en     = 1'b0;
    sink_hold_cycles = 150;
    run_random_ticks(60, 10, 3, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin : main_sequence
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_settings();
    test_directed_commands();
    test_oneshot_traffic();
    test_continuous_traffic();
    test_zero_settings();
    test_fifo_overflow();
    test_extreme_settings();
    test_single_tick_shot();
    test_random_settings();
    test_backpressure();

    // Let the last words out, then allow a few more cycles for anything
    // the block might still emit unasked.
    drain_results();
    repeat (4) @(posedge clk_i);
    if (tick_outputs_q.size() != 0) begin
      note_failure($sformatf("%0d predicted words never came out", tick_outputs_q.size()));
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // The slowest correct run takes well under a tenth of this.
  initial begin : watchdog
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
